// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the cache RTL.
// Each macro takes a label, a clock, a property and a message string; HTRC_ASSERT also takes a reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while reset is low.
`define HTRC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, during reset as well.
`define HTRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HTRC_ASSERT(lbl, clk, rst, prop, msg)
`define HTRC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hdl/htrc_pkg.sv -----
`timescale 1ns / 1ps

package htrc_pkg;

  // Field widths.
  localparam int HASH_W   = 64;
  localparam int LEN_W    = 16;
  localparam int TIER_W   = 2;
  localparam int STAMP_W  = 32;
  localparam int BYTE_W   = 8;
  localparam int SLOT_W   = 6;

  // Stream data widths, padded to whole bytes.
  localparam int IN_FIELDS_W  = BYTE_W + STAMP_W + TIER_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + TIER_W + SLOT_W + HASH_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // FNV-1a 64-bit constants.
  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [LEN_W-1:0]  LEN_MAX   = 16'hffff;

  // Configuration reset value and default sizes.
  localparam logic [STAMP_W-1:0] TTL_RESET = 32'd3600;
  localparam int CACHE_ENTRIES_DEF = 64;
  localparam int PROBE_LIMIT_DEF   = 4;
  localparam int QUEUE_DEPTH       = 2;

  // Request kinds.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // One finished message handed from the hasher to the table engine.
  typedef struct packed {
    logic                req_kind;
    logic [HASH_W-1:0]   key_hash;
    logic [LEN_W-1:0]    key_len;
    logic [STAMP_W-1:0]  now_secs;
    logic [TIER_W-1:0]   put_tier;
  } req_t;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic                valid;
    logic [HASH_W-1:0]   key_hash;
    logic [LEN_W-1:0]    key_len;
    logic [TIER_W-1:0]   tier;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

  // One result item.
  typedef struct packed {
    logic                hit;
    logic [TIER_W-1:0]   found_tier;
    logic [SLOT_W-1:0]   slot_index;
    logic [HASH_W-1:0]   key_hash;
  } res_t;

endpackage

// ----- hdl/htrc_ram.sv -----
`timescale 1ns / 1ps

module htrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/htrc_front.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htrc_front import htrc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               enable,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               in_last,
  input  logic [STAMP_W-1:0] in_now,
  input  logic [TIER_W-1:0]  in_tier,
  output logic               push_valid,
  input  logic               push_ready,
  output req_t               push_data
);

  logic [HASH_W-1:0] run_hash;
  logic [LEN_W-1:0]  run_length;
  logic [HASH_W-1:0] hash_next;
  logic [LEN_W-1:0]  length_next;
  logic              accept;

  // One FNV-1a round: xor the byte, then multiply by 2^40 + 0x1b3 as shifted adds.
  function automatic logic [HASH_W-1:0] fnv_round(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W - BYTE_W){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  // A byte is taken only when the queue can hold a finished message.
  assign in_ready = enable && push_ready;
  assign accept   = in_valid && in_ready;

  assign hash_next   = fnv_round(run_hash, in_byte);
  assign length_next = (run_length == LEN_MAX) ? run_length : run_length + 1'b1;

  // The last byte hands the finished key to the queue.
  assign push_valid         = accept && in_last;
  assign push_data.req_kind = in_kind;
  assign push_data.key_hash = hash_next;
  assign push_data.key_len  = length_next;
  assign push_data.now_secs = in_now;
  assign push_data.put_tier = in_tier;

  // Running hash and length; both restart after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_hash   <= FNV_BASIS;
      run_length <= '0;
    end else if (accept) begin
      if (in_last) begin
        run_hash   <= FNV_BASIS;
        run_length <= '0;
      end else begin
        run_hash   <= hash_next;
        run_length <= length_next;
      end
    end
  end

  `HTRC_ASSERT(a_run_restart, clk, rst, (accept && in_last) |=> (run_length == '0 && run_hash == FNV_BASIS), "hash state did not restart after the last byte")

endmodule

// ----- hdl/htrc_fifo.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htrc_fifo import htrc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  req_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output req_t rd_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  req_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Storage for queued requests.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `HTRC_ASSERT(a_fill_track, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1), "queue count lost a push")

endmodule

// ----- hdl/htrc_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htrc_back import htrc_pkg::*; #(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  parameter int PROBE_LIMIT   = PROBE_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [STAMP_W-1:0] cfg_data,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               out_valid,
  input  logic               out_ready,
  output res_t               out_data,
  output logic               clear_busy
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int PRB_W = $clog2(PROBE_LIMIT + 1);
  localparam int BIT_W = $clog2(HASH_W);
  localparam bit IS_POW2 = ((CACHE_ENTRIES & (CACHE_ENTRIES - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(CACHE_ENTRIES - 1);
  localparam logic [PRB_W-1:0] LAST_PROBE = PRB_W'(PROBE_LIMIT - 1);
  localparam logic [IDX_W:0]   ENTRIES_W  = (IDX_W + 1)'(CACHE_ENTRIES);
  localparam logic [BIT_W-1:0] TOP_BIT    = BIT_W'(HASH_W - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_WRITE,
    ST_DONE
  } state_t;

  state_t             state;
  logic [STAMP_W-1:0] ttl;
  req_t               cur;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   start;
  logic [IDX_W-1:0]   best;
  logic [PRB_W-1:0]   probe;
  logic [BIT_W-1:0]   bitcnt;
  logic               hit_r;
  logic [TIER_W-1:0]  tier_r;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               rd_en;
  entry_t             rd_data;

  logic [STAMP_W-1:0] age;
  logic               stale;
  logic               same_key;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W:0]     mod_tmp;
  logic [IDX_W:0]     mod_sub;
  logic [IDX_W-1:0]   mod_next;
  logic               out_free;

  htrc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  assign cfg_ready  = 1'b1;
  assign req_ready  = (state == ST_IDLE);
  assign clear_busy = (state == ST_CLEAR);
  assign out_free   = !out_valid || out_ready;

  // Table port control: the clearing pass and inserts write, probes read.
  assign rd_en   = (state == ST_READ);
  assign wr_en   = (state == ST_CLEAR) || (state == ST_WRITE);
  assign wr_addr = (state == ST_CLEAR) ? idx : best;
  always_comb begin
    if (state == ST_CLEAR) begin
      wr_data = '0;
    end else begin
      wr_data.valid    = 1'b1;
      wr_data.key_hash = cur.key_hash;
      wr_data.key_len  = cur.key_len;
      wr_data.tier     = cur.put_tier;
      wr_data.stamp    = cur.now_secs;
    end
  end

  // Entry classification; the age wraps modulo 2^32.
  assign age      = cur.now_secs - rd_data.stamp;
  assign stale    = (age >= ttl);
  assign same_key = (rd_data.key_hash == cur.key_hash) && (rd_data.key_len == cur.key_len);
  assign idx_inc  = (idx == LAST_IDX) ? '0 : idx + 1'b1;

  // One bit of the hash remainder per cycle, most significant bit first.
  assign mod_tmp  = {start, cur.key_hash[bitcnt]};
  assign mod_sub  = mod_tmp - ENTRIES_W;
  assign mod_next = (mod_tmp >= ENTRIES_W) ? mod_sub[IDX_W-1:0] : mod_tmp[IDX_W-1:0];

  // Sequencer for the clearing pass, the start slot, the probes and the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      ttl       <= TTL_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ttl <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          idx <= idx_inc;
          if (idx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            cur    <= req;
            probe  <= '0;
            hit_r  <= 1'b0;
            tier_r <= '0;
            best   <= '0;
            if (IS_POW2) begin
              start <= req.key_hash[IDX_W-1:0];
              idx   <= req.key_hash[IDX_W-1:0];
              state <= ST_READ;
            end else begin
              start  <= '0;
              bitcnt <= TOP_BIT;
              state  <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          start  <= mod_next;
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == '0) begin
            idx   <= mod_next;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (cur.req_kind == REQ_LOOKUP) begin
            // A lookup ends at an empty slot, a fresh match or the last probe.
            if (!rd_data.valid) begin
              state <= ST_DONE;
            end else if (same_key && !stale) begin
              hit_r  <= 1'b1;
              tier_r <= rd_data.tier;
              best   <= idx;
              state  <= ST_DONE;
            end else if (probe == LAST_PROBE) begin
              state <= ST_DONE;
            end else begin
              probe <= probe + 1'b1;
              idx   <= idx_inc;
              state <= ST_READ;
            end
          end else begin
            // An insert takes an empty, stale or same-key slot, else the start slot.
            if (!rd_data.valid || stale || same_key) begin
              best  <= idx;
              state <= ST_WRITE;
            end else if (probe == LAST_PROBE) begin
              best  <= start;
              state <= ST_WRITE;
            end else begin
              probe <= probe + 1'b1;
              idx   <= idx_inc;
              state <= ST_READ;
            end
          end
        end
        ST_WRITE: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data.hit        <= hit_r;
            out_data.found_tier <= tier_r;
            out_data.slot_index <= SLOT_W'(best);
            out_data.key_hash   <= cur.key_hash;
            out_valid           <= 1'b1;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `HTRC_ASSERT(a_clear_once, clk, rst, (state != ST_CLEAR) |=> (state != ST_CLEAR), "clearing pass restarted without reset")
  `HTRC_ASSERT(a_probe_bound, clk, rst, (state == ST_CHECK) |-> (probe <= LAST_PROBE), "probe count past its limit")
  `HTRC_ASSERT(a_slot_range, clk, rst, (state == ST_READ) |-> (idx <= LAST_IDX), "probe slot outside the table")
  `HTRC_ASSERT(a_insert_no_hit, clk, rst, (state == ST_WRITE) |-> (!hit_r && cur.req_kind == REQ_INSERT), "insert marked as hit")

endmodule

// ----- hdl/hashed_ttl_result_cache_top.sv -----
`timescale 1ns / 1ps
// Hashed result cache with entry lifetime.
// Input stream s_axis: one message byte per item; tlast marks the final byte.
// On the final byte the key's FNV-1a 64-bit hash and saturated length look up
// or insert an entry in an open-addressing table, probing consecutive slots.
// Output stream m_axis: one result per message (hit, tier, slot, hash).
// cfg channel: writes the entry lifetime in seconds (reset value 3600).
// Bytes are hashed at one per cycle while s_axis_tready is high; it falls when
// the queue is full. For each message end the table engine reads the RAM and
// compares the entry once per probe, after a bit-serial remainder of the hash
// when the table size is not a power of two. A two-entry queue lets the hasher
// keep taking bytes while the engine works.
// Reset: after rst falls, a clearing pass over the CACHE_ENTRIES slots empties the
// table; s_axis_tready stays low during it, configuration writes are taken.
// A stalled receiver holds the result in the output register; the engine then
// stops, the queue fills and s_axis_tready falls.
module hashed_ttl_result_cache_top import htrc_pkg::*; #(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  parameter int PROBE_LIMIT   = PROBE_LIMIT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // msg_byte [7:0], now_secs [39:8], put_tier [41:40], zero pad above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hit [0], found_tier [2:1], slot_index [8:3], key_hash [72:9], zero pad above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [STAMP_W-1:0]     cfg_data
);

  logic clear_busy;
  logic push_valid;
  logic push_ready;
  req_t push_data;
  logic pop_valid;
  logic pop_ready;
  req_t pop_data;
  res_t result;

  htrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (!clear_busy),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_kind    (s_axis_tuser),
    .in_byte    (s_axis_tdata[BYTE_W-1:0]),
    .in_last    (s_axis_tlast),
    .in_now     (s_axis_tdata[BYTE_W +: STAMP_W]),
    .in_tier    (s_axis_tdata[BYTE_W + STAMP_W +: TIER_W]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  htrc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  htrc_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .PROBE_LIMIT   (PROBE_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .req_valid  (pop_valid),
    .req_ready  (pop_ready),
    .req        (pop_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (result),
    .clear_busy (clear_busy)
  );

  // Result fields packed from the lowest bit up.
  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                         result.key_hash, result.slot_index,
                         result.found_tier, result.hit};

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import htrc_pkg::*;

  localparam logic [HASH_W-1:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
  localparam int PROBES         = PROBE_LIMIT_DEF;
  localparam int KEY_MAX        = 6;
  localparam int POOL_KEYS      = 24;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int LONG_KEY_BYTES = 65600;

  // One message byte together with the fields sampled on the final byte.
  typedef struct packed {
    logic               req_kind;
    logic [BYTE_W-1:0]  msg_byte;
    logic               last_byte;
    logic [STAMP_W-1:0] now_secs;
    logic [TIER_W-1:0]  put_tier;
  } msg_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // msg_byte [7:0], now_secs [39:8], put_tier [41:40], zero pad above
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // req_type
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // hit [0], found_tier [2:1], slot_index [8:3], key_hash [72:9], zero pad above
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [STAMP_W-1:0]     cfg_data = '0;

  // Shadow copy of the hasher, the table and the lifetime register.
  logic [HASH_W-1:0]  shadow_hash = FNV_BASIS;
  logic [LEN_W-1:0]   shadow_len = '0;
  logic [STAMP_W-1:0] shadow_ttl = TTL_RESET;
  entry_t             shadow_table [CACHE_ENTRIES_DEF];
  res_t               cache_answers [$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic [STAMP_W-1:0] clock_secs = '0;

  logic [8*KEY_MAX-1:0] pool_key [POOL_KEYS];
  int                   pool_len [POOL_KEYS];

  hashed_ttl_result_cache_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One FNV-1a step: xor the byte in, then multiply by the prime.
  function automatic logic [HASH_W-1:0] fnv_fold(logic [HASH_W-1:0] h, logic [BYTE_W-1:0] b);
    return (h ^ {{(HASH_W-BYTE_W){1'b0}}, b}) * FNV_PRIME;
  endfunction

  // Age wraps modulo 2^32, so a stamp from the future looks very old.
  function automatic logic entry_stale(entry_t e, logic [STAMP_W-1:0] now);
    logic [STAMP_W-1:0] age;
    age = now - e.stamp;
    return age >= shadow_ttl;
  endfunction

  // Fold one accepted byte and, on the final byte, run the probe sequence.
  function automatic void predict_cache_answer(msg_item_t it);
    logic [SLOT_W-1:0] start_slot;
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] chosen;
    logic              searching;
    logic              same_key;
    res_t              ans;
    int                p;
    shadow_hash = fnv_fold(shadow_hash, it.msg_byte);
    if (shadow_len != LEN_MAX) begin
      shadow_len = shadow_len + 1'b1;
    end
    if (it.last_byte) begin
      ans = '0;
      ans.key_hash = shadow_hash;
      start_slot = shadow_hash[SLOT_W-1:0];
      chosen = start_slot;
      searching = 1'b1;
      for (p = 0; p < PROBES && searching; p++) begin
        idx = start_slot + p[SLOT_W-1:0];
        same_key = shadow_table[idx].key_hash == shadow_hash &&
                   shadow_table[idx].key_len == shadow_len;
        if (it.req_kind == REQ_LOOKUP) begin
          // A lookup ends at the first empty slot and skips stale or foreign keys.
          if (!shadow_table[idx].valid) begin
            searching = 1'b0;
          end else if (same_key && !entry_stale(shadow_table[idx], it.now_secs)) begin
            ans.hit = 1'b1;
            ans.found_tier = shadow_table[idx].tier;
            ans.slot_index = idx;
            searching = 1'b0;
          end
        end else if (!shadow_table[idx].valid || same_key ||
                     entry_stale(shadow_table[idx], it.now_secs)) begin
          chosen = idx;
          searching = 1'b0;
        end
      end
      // An insert with no usable slot overwrites the start slot.
      if (it.req_kind == REQ_INSERT) begin
        shadow_table[chosen].valid = 1'b1;
        shadow_table[chosen].key_hash = shadow_hash;
        shadow_table[chosen].key_len = shadow_len;
        shadow_table[chosen].tier = it.put_tier;
        shadow_table[chosen].stamp = it.now_secs;
        ans.slot_index = chosen;
      end
      cache_answers.push_back(ans);
      shadow_hash = FNV_BASIS;
      shadow_len = '0;
    end
  endfunction

  // Offer one byte, idling first at random, and predict once it is taken.
  task automatic send_item(msg_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, it.put_tier, it.now_secs, it.msg_byte};
    s_axis_tuser <= it.req_kind;
    s_axis_tlast <= it.last_byte;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    predict_cache_answer(it);
  endtask

  // Send a whole key; fields that only matter on the final byte are random before it.
  task automatic send_message(input logic [8*KEY_MAX-1:0] key, input int len, input logic kind,
                              input logic [STAMP_W-1:0] now, input logic [TIER_W-1:0] tier);
    msg_item_t it;
    for (int i = 0; i < len; i++) begin
      it.msg_byte = key[8*i +: 8];
      it.last_byte = (i == len - 1);
      if (it.last_byte) begin
        it.req_kind = kind;
        it.now_secs = now;
        it.put_tier = tier;
      end else begin
        it.req_kind = $urandom_range(1);
        it.now_secs = $urandom;
        it.put_tier = $urandom_range(3);
      end
      send_item(it);
    end
  endtask

  // Stop offering bytes and let every pending answer come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (cache_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ttl(logic [STAMP_W-1:0] ttl);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= ttl;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    shadow_ttl = ttl;
  endtask

  // Empty table, wrapped ages, lifetime boundary and a full probe window.
  task automatic test_directed();
    logic [8*KEY_MAX-1:0] ring_keys [5];
    logic [HASH_W-1:0]    h;
    int                   found;
    send_message('h00, 1, REQ_LOOKUP, 32'd0, 2'd0);
    send_message('hFF, 1, REQ_INSERT, 32'hFFFF_FFFF, 2'd3);
    send_message('hFF, 1, REQ_LOOKUP, 32'd0, 2'd0);
    send_message('hFF, 1, REQ_LOOKUP, 32'd3599, 2'd0);
    send_message('hFF, 1, REQ_LOOKUP, 32'hFFFF_FFFE, 2'd0);
    // Five two-byte keys that all start at the top slot, so probing wraps.
    found = 0;
    for (int a = 0; a < 256 && found < 5; a++) begin
      for (int b = 0; b < 256 && found < 5; b++) begin
        h = fnv_fold(fnv_fold(FNV_BASIS, a[7:0]), b[7:0]);
        if (h[SLOT_W-1:0] == {SLOT_W{1'b1}}) begin
          ring_keys[found] = '0;
          ring_keys[found][7:0] = a[7:0];
          ring_keys[found][15:8] = b[7:0];
          found++;
        end
      end
    end
    for (int i = 0; i < 5; i++) begin
      send_message(ring_keys[i], 2, REQ_INSERT, 32'd1000, i[1:0]);
    end
    send_message(ring_keys[0], 2, REQ_LOOKUP, 32'd1001, 2'd0);
    send_message(ring_keys[4], 2, REQ_LOOKUP, 32'd1001, 2'd0);
    send_message(ring_keys[3], 2, REQ_LOOKUP, 32'd1001, 2'd0);
  endtask

  // A key longer than the length counter, inserted and then looked up.
  task automatic test_long_message();
    msg_item_t it;
    for (int rep = 0; rep < 2; rep++) begin
      for (int i = 0; i < LONG_KEY_BYTES; i++) begin
        it.msg_byte = i[7:0] ^ i[15:8];
        it.last_byte = (i == LONG_KEY_BYTES - 1);
        it.req_kind = (rep == 0) ? REQ_INSERT : REQ_LOOKUP;
        it.now_secs = clock_secs;
        it.put_tier = 2'd2;
        send_item(it);
      end
    end
  endtask

  // Mostly keys from a small pool so inserts are found again, plus fresh keys.
  task automatic test_random(int n_items, logic [STAMP_W-1:0] ttl, int send_idle, int recv_stall);
    logic [8*KEY_MAX-1:0] key;
    int                   len;
    int                   k;
    int                   sent;
    write_ttl(ttl);
    send_idle_pct = send_idle;
    recv_stall_pct <= recv_stall;
    for (k = 0; k < POOL_KEYS; k++) begin
      pool_len[k] = $urandom_range(1, 4);
      pool_key[k] = {$urandom, $urandom};
    end
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 75) begin
        k = $urandom_range(POOL_KEYS - 1);
        key = pool_key[k];
        len = pool_len[k];
      end else begin
        key = {$urandom, $urandom};
        len = $urandom_range(1, KEY_MAX);
      end
      // Time creeps forward, with rare jumps to anywhere.
      if ($urandom_range(99) < 5) begin
        clock_secs = $urandom;
      end else begin
        clock_secs = clock_secs + $urandom_range(0, 3);
      end
      send_message(key, len, $urandom_range(1), clock_secs, $urandom_range(3));
      sent += len;
    end
  endtask

  // Receiver holds off while short messages keep coming, so the input stalls.
  task automatic test_backpressure();
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 40; i++) begin
      send_message($urandom_range(255), 1, $urandom_range(1), clock_secs, $urandom_range(3));
    end
  endtask

  // Receiver ready: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [HASH_W-1:0] want,
                                      logic [HASH_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Compare every answer taken from the block with the oldest prediction.
  always @(posedge clk) begin : answer_check
    res_t want;
    logic [OUT_TDATA_W-1:0] d;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      d = m_axis_tdata;
      if (cache_answers.size() == 0) begin
        $display("%0t ns: answer with none pending, actual %0h", $time, d);
        fail_count++;
      end else begin
        want = cache_answers.pop_front();
        check_field("hit", want.hit, d[0]);
        check_field("found_tier", want.found_tier, d[1 +: TIER_W]);
        check_field("slot_index", want.slot_index, d[1 + TIER_W +: SLOT_W]);
        check_field("key_hash", want.key_hash, d[1 + TIER_W + SLOT_W +: HASH_W]);
      end
    end
  end

  initial begin
    foreach (shadow_table[i]) begin
      shadow_table[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_long_message();
    test_random(300, 32'd50, 0, 0);
    test_random(250, 32'd1, 71, 0);
    test_random(250, 32'hFFFF_FFFF, 0, 71);
    test_random(300, 32'd20, 25, 25);
    test_backpressure();
    wait_drained();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/htrc_pkg.sv
hdl/htrc_ram.sv
hdl/htrc_front.sv
hdl/htrc_fifo.sv
hdl/htrc_back.sv
hdl/hashed_ttl_result_cache_top.sv
verif/testbench.sv
